### rtl/ring_list_move_engine_unit_assert.svh
// Assertion macros for the ring list move engine.
// Included by the top level. No other dependencies.
`ifndef RING_LIST_MOVE_ENGINE_UNIT_ASSERT_SVH
`define RING_LIST_MOVE_ENGINE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RLME_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define RLME_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/rlme_pkg.sv
// Shared types and constants for the ring list move engine.
// No dependencies; imported by the top level.
package rlme_pkg;

  // Fixed field widths of the stream payloads.
  localparam int NODE_W     = 10;
  localparam int SIZE_W     = 11;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;
  localparam int OP_W       = 2;

  // Ring size after reset.
  localparam logic [SIZE_W-1:0] RING_SIZE_RESET = 11'd1024;

  // Item kinds carried on the input tuser.
  typedef enum logic [OP_W-1:0] {
    OP_INIT       = 2'd0,
    OP_MOVE_LEFT  = 2'd1,
    OP_MOVE_RIGHT = 2'd2,
    OP_QUERY      = 2'd3
  } opcode_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_UNLINK,
    ST_READ_B,
    ST_LINK_B,
    ST_LINK_A,
    ST_QUERY_RES
  } state_t;

endpackage

### rtl/ring_list_move_engine_unit.sv
// Ring list move engine: circular doubly linked list held in two link memories.
// Depends on rlme_pkg and ring_list_move_engine_unit_assert.svh.
//
//  Channel | Group    | Contents
//  --------+----------+---------------------------------------------------------
//  input   | in_*     | tuser: opcode; tdata: node_a, node_b
//  result  | out_*    | tuser: bad_index; tdata: left_neighbour, right_neighbour
//  config  | cfg_*    | ring_size write, no read-back
//
// Init covers N entries, N being the clamped ring size: a shared index counter
// writes one entry of each link memory per cycle. A move runs as read of
// node_a, unlink write, read of node_b and two relink writes, bounded by the
// single read and write port of each memory. Ignored moves end in the
// accept cycle. in_tready is high only when idle, and a finished query waits
// for a free output register. Reset clears control state, not the link memories.
`include "ring_list_move_engine_unit_assert.svh"

module ring_list_move_engine_unit #(
  parameter int MAX_NODES = 1024
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Configuration write.
  input  logic                             cfg_wr_en,
  input  logic [rlme_pkg::SIZE_W-1:0]      cfg_wr_data,   // ring_size
  // Input stream.
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [rlme_pkg::IN_DATA_W-1:0]   in_tdata,      // [9:0] node_a, [19:10] node_b
  input  logic [rlme_pkg::OP_W-1:0]        in_tuser,      // [1:0] opcode
  // Result stream.
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [rlme_pkg::OUT_DATA_W-1:0]  out_tdata,     // [9:0] left_neighbour,
                                                          // [19:10] right_neighbour
  output logic                             out_tuser      // [0] bad_index
);
  import rlme_pkg::*;

  // Link width and size width follow from the node count.
  localparam int LW    = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1;
  localparam int SW_MX = $clog2(MAX_NODES + 1);
  localparam int SW    = (SW_MX > SIZE_W) ? SW_MX : SIZE_W;
  localparam logic [SW-1:0] MAX_SIZE = SW'(MAX_NODES);
  localparam logic [SW-1:0] ONE_SIZE = SW'(1);

  // Node field to memory address.
  function automatic logic [LW-1:0] to_addr(input logic [NODE_W-1:0] v);
    logic [LW+NODE_W-1:0] t;
    t = {{LW{1'b0}}, v};
    return t[LW-1:0];
  endfunction

  // Link value to node field.
  function automatic logic [NODE_W-1:0] to_node(input logic [LW-1:0] v);
    logic [LW+NODE_W-1:0] t;
    t = {{NODE_W{1'b0}}, v};
    return t[NODE_W-1:0];
  endfunction

  // Node field widened for size compares.
  function automatic logic [SW-1:0] to_size(input logic [NODE_W-1:0] v);
    return {{(SW-NODE_W){1'b0}}, v};
  endfunction

  state_t             state_r, state_nxt;
  logic [SIZE_W-1:0]  ring_size_r;
  logic [SW-1:0]      eff_size;
  logic [SW-1:0]      ring_ext;

  logic [LW-1:0]      a_r, a_nxt;
  logic [LW-1:0]      b_r, b_nxt;
  logic               to_left_r, to_left_nxt;
  logic               q_bad_r, q_bad_nxt;
  logic [LW-1:0]      idx_r, idx_nxt;
  logic               idx_last;

  logic               out_tvalid_r, out_tvalid_nxt;
  logic [NODE_W-1:0]  out_left_r, out_left_nxt;
  logic [NODE_W-1:0]  out_right_r, out_right_nxt;
  logic               out_bad_r, out_bad_nxt;
  logic               out_load;

  // Link memories and their registered read data.
  logic [LW-1:0]      left_links_r  [MAX_NODES];
  logic [LW-1:0]      right_links_r [MAX_NODES];
  logic [LW-1:0]      rd_left_r, rd_right_r;
  logic               rd_en;
  logic [LW-1:0]      rd_addr;
  logic               wr_left_en, wr_right_en;
  logic [LW-1:0]      wr_left_addr, wr_right_addr;
  logic [LW-1:0]      wr_left_data, wr_right_data;

  // Input decode.
  opcode_t            in_op;
  logic [NODE_W-1:0]  in_node_a, in_node_b;
  logic               in_accept;
  logic               a_ok, b_ok, move_ok;

  assign in_op     = opcode_t'(in_tuser);
  assign in_node_a = in_tdata[NODE_W-1:0];
  assign in_node_b = in_tdata[2*NODE_W-1:NODE_W];
  assign in_tready = (state_r == ST_IDLE);
  assign in_accept = in_tvalid && in_tready;

  // Effective ring size: the register clamped to 1..MAX_NODES.
  always_comb begin
    ring_ext = SW'(ring_size_r);
    if (ring_ext == '0) begin
      eff_size = ONE_SIZE;
    end else if (ring_ext > MAX_SIZE) begin
      eff_size = MAX_SIZE;
    end else begin
      eff_size = ring_ext;
    end
  end

  assign a_ok     = to_size(in_node_a) < eff_size;
  assign b_ok     = to_size(in_node_b) < eff_size;
  assign move_ok  = a_ok && b_ok && (in_node_a != in_node_b);
  assign idx_last = ({{(SW-LW){1'b0}}, idx_r} + ONE_SIZE) == eff_size;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_size_r <= RING_SIZE_RESET;
    end else if (cfg_wr_en) begin
      ring_size_r <= cfg_wr_data;
    end
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          case (in_op)
            OP_INIT:                      state_nxt = ST_INIT;
            OP_MOVE_LEFT, OP_MOVE_RIGHT:  state_nxt = move_ok ? ST_UNLINK : ST_IDLE;
            OP_QUERY:                     state_nxt = ST_QUERY_RES;
            default:                      state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_INIT:      state_nxt = idx_last ? ST_IDLE : ST_INIT;
      ST_UNLINK:    state_nxt = ST_READ_B;
      ST_READ_B:    state_nxt = ST_LINK_B;
      ST_LINK_B:    state_nxt = ST_LINK_A;
      ST_LINK_A:    state_nxt = ST_IDLE;
      ST_QUERY_RES: state_nxt = out_load ? ST_IDLE : ST_QUERY_RES;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // Output logic: memory ports, working registers and the result register.
  always_comb begin
    rd_en         = 1'b0;
    rd_addr       = to_addr(in_node_a);
    wr_left_en    = 1'b0;
    wr_right_en   = 1'b0;
    wr_left_addr  = a_r;
    wr_right_addr = a_r;
    wr_left_data  = b_r;
    wr_right_data = b_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    to_left_nxt   = to_left_r;
    q_bad_nxt     = q_bad_r;
    idx_nxt       = idx_r;
    out_load      = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          a_nxt       = to_addr(in_node_a);
          b_nxt       = to_addr(in_node_b);
          to_left_nxt = (in_op == OP_MOVE_LEFT);
          q_bad_nxt   = !a_ok;
          idx_nxt     = '0;
          case (in_op)
            OP_MOVE_LEFT, OP_MOVE_RIGHT: rd_en = move_ok;
            OP_QUERY:                    rd_en = a_ok;
            default:                     rd_en = 1'b0;
          endcase
        end
      end
      ST_INIT: begin
        // One entry of each table per cycle, wrapping at both ends.
        wr_left_en    = 1'b1;
        wr_right_en   = 1'b1;
        wr_left_addr  = idx_r;
        wr_right_addr = idx_r;
        wr_left_data  = (idx_r == '0) ? LW'(eff_size - ONE_SIZE) : idx_r - LW'(1);
        wr_right_data = idx_last ? '0 : idx_r + LW'(1);
        idx_nxt       = idx_r + LW'(1);
      end
      ST_UNLINK: begin
        // Join node_a's old neighbors to each other.
        wr_right_en   = 1'b1;
        wr_right_addr = rd_left_r;
        wr_right_data = rd_right_r;
        wr_left_en    = 1'b1;
        wr_left_addr  = rd_right_r;
        wr_left_data  = rd_left_r;
      end
      ST_READ_B: begin
        rd_en   = 1'b1;
        rd_addr = b_r;
      end
      ST_LINK_B: begin
        // Point node_b and its neighbor on the insert side at node_a.
        wr_left_en  = 1'b1;
        wr_right_en = 1'b1;
        wr_left_data  = a_r;
        wr_right_data = a_r;
        if (to_left_r) begin
          wr_right_addr = rd_left_r;
          wr_left_addr  = b_r;
        end else begin
          wr_left_addr  = rd_right_r;
          wr_right_addr = b_r;
        end
      end
      ST_LINK_A: begin
        // Give node_a its new neighbors.
        wr_left_en    = 1'b1;
        wr_right_en   = 1'b1;
        wr_left_addr  = a_r;
        wr_right_addr = a_r;
        if (to_left_r) begin
          wr_left_data  = rd_left_r;
          wr_right_data = b_r;
        end else begin
          wr_left_data  = b_r;
          wr_right_data = rd_right_r;
        end
      end
      ST_QUERY_RES: begin
        out_load = !out_tvalid_r || out_tready;
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  // Result register; it is freed by the downstream transaction.
  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    out_left_nxt   = out_left_r;
    out_right_nxt  = out_right_r;
    out_bad_nxt    = out_bad_r;
    if (out_load) begin
      out_tvalid_nxt = 1'b1;
      out_left_nxt   = q_bad_r ? '0 : to_node(rd_left_r);
      out_right_nxt  = q_bad_r ? '0 : to_node(rd_right_r);
      out_bad_nxt    = q_bad_r;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    to_left_r   <= to_left_nxt;
    q_bad_r     <= q_bad_nxt;
    idx_r       <= idx_nxt;
    out_left_r  <= out_left_nxt;
    out_right_r <= out_right_nxt;
    out_bad_r   <= out_bad_nxt;
  end

  // Left link memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_left_en) begin
      left_links_r[wr_left_addr] <= wr_left_data;
    end
    if (rd_en) begin
      rd_left_r <= left_links_r[rd_addr];
    end
  end

  // Right link memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_right_en) begin
      right_links_r[wr_right_addr] <= wr_right_data;
    end
    if (rd_en) begin
      rd_right_r <= right_links_r[rd_addr];
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(OUT_DATA_W-2*NODE_W){1'b0}}, out_right_r, out_left_r};
  assign out_tuser  = out_bad_r;

  // A result flagged as a bad index carries zero neighbors.
  `RLME_ASSERT_NOW(a_bad_zero, clk, rst_n, out_tvalid_r && out_bad_r,
                   out_left_r == '0 && out_right_r == '0, "bad index result with nonzero data")

  // Memories are written only by the init sweep and the move steps.
  `RLME_ASSERT_NOW(a_wr_states, clk, rst_n, wr_left_en || wr_right_en,
                   state_r == ST_INIT || state_r == ST_UNLINK ||
                   state_r == ST_LINK_B || state_r == ST_LINK_A,
                   "link write outside a write step")

  // The init sweep never indexes past the ring.
  `RLME_ASSERT_NOW(a_init_range, clk, rst_n, state_r == ST_INIT,
                   {{(SW-LW){1'b0}}, idx_r} < eff_size, "init index beyond ring size")

  // A valid move always starts with the unlink step.
  `RLME_ASSERT_NEXT(a_move_start, clk, rst_n,
                    in_accept && move_ok &&
                    (in_op == OP_MOVE_LEFT || in_op == OP_MOVE_RIGHT),
                    state_r == ST_UNLINK, "valid move did not start unlink")

  // A finished query holds while the result register is still occupied.
  `RLME_ASSERT_NEXT(a_query_hold, clk, rst_n,
                    state_r == ST_QUERY_RES && out_tvalid_r && !out_tready,
                    state_r == ST_QUERY_RES, "query result dropped while output busy")

endmodule
